@@ src/crcpd_pkg.sv @@
// Shared types, constants and the CRC16-CCITT byte update for the packet deframer.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package crcpd_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;

    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int FIELD_W  = 16;
    localparam int LEN_W    = 32;
    localparam int OLEN_W   = 11;
    localparam int STATUS_W = 2;

    localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;
    localparam logic [OLEN_W-1:0] LEN_SAT      = 11'd1024;
    localparam logic [3:0]        HEADER_BYTES = 4'd10;
    localparam logic [BYTE_W-1:0] MAGIC_LO     = 8'h55;
    localparam logic [BYTE_W-1:0] MAGIC_HI     = 8'haa;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRC_INIT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LEN  = 1'd1;

    localparam logic [CRC_W-1:0]  CRC_INIT_RST = 16'hffff;
    localparam logic [OLEN_W-1:0] MAX_LEN_RST  = 11'd1024;

    // result kinds and frame status codes
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_CRC_LO  = 5'b01000,
        PH_CRC_HI  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  total;
        logic [FIELD_W-1:0]  index;
        logic [FIELD_W-1:0]  ptype;
        logic [OLEN_W-1:0]   length;
    } t_result;

    // one byte through CRC16-CCITT, MSB first, not reflected
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // CRC after the four magic bytes 55 55 aa aa
    function automatic logic [CRC_W-1:0] crc_magic(input logic [CRC_W-1:0] init);
        logic [CRC_W-1:0] c;
        c = crc_byte(init, MAGIC_LO);
        c = crc_byte(c, MAGIC_LO);
        c = crc_byte(c, MAGIC_HI);
        c = crc_byte(c, MAGIC_HI);
        return c;
    endfunction

endpackage

@@ src/crcpd_in_reg.sv @@
// Input register stage of the packet deframer: holds one received byte.
// Depends on crcpd_pkg.
`timescale 1ns / 1ps

module crcpd_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [crcpd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                          i_take,
    output logic                          o_valid,
    output logic [crcpd_pkg::BYTE_W-1:0]  o_byte
);
    import crcpd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

@@ src/crcpd_fsm.sv @@
// Frame state machine: magic hunt, header capture with length limit check, payload count and CRC check.
// Handles one byte per step; depends on crcpd_pkg.
`timescale 1ns / 1ps

module crcpd_fsm #(
    parameter int MAX_PAYLOAD = crcpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [crcpd_pkg::BYTE_W-1:0]  i_byte,
    input  logic [crcpd_pkg::CRC_W-1:0]   i_crc_init,
    input  logic [crcpd_pkg::OLEN_W-1:0]  i_max_len,
    output logic                          o_res_valid,
    output crcpd_pkg::t_result            o_res
);
    import crcpd_pkg::*;

    localparam int LIMIT_MAX = (MAX_PAYLOAD < 2047) ? MAX_PAYLOAD : 2047;
    localparam int CNT_W     = $clog2(LIMIT_MAX + 1);

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [FIELD_W-1:0] r_total, n_total;
    logic [FIELD_W-1:0] r_index, n_index;
    logic [FIELD_W-1:0] r_ptype, n_ptype;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [BYTE_W-1:0]  r_crc_lo, n_crc_lo;

    logic [CRC_W-1:0]   crc_next;
    logic [CNT_W:0]     cnt_inc;
    logic [LEN_W-1:0]   limit;
    logic               is_magic_byte;

    assign crc_next = crc_byte(r_crc, i_byte);
    assign cnt_inc  = {1'b0, r_cnt} + 1'b1;
    assign limit    = (LEN_W'(i_max_len) > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                                : LEN_W'(i_max_len);
    assign is_magic_byte = (r_cnt[1] ? MAGIC_HI : MAGIC_LO) == i_byte;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_index     = r_index;
        n_ptype     = r_ptype;
        n_len       = r_len;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        o_res_valid = 1'b0;
        o_res.kind         = KIND_STATUS;
        o_res.payload_byte = '0;
        o_res.status       = ST_OK;

        unique case (r_phase)
            PH_HUNT: begin
                // a byte that breaks a partial match may start a new one
                if (is_magic_byte) begin
                    n_cnt = cnt_inc[CNT_W-1:0];
                end else if (i_byte == MAGIC_LO) begin
                    n_cnt = (r_cnt == CNT_W'(2)) ? CNT_W'(2) : CNT_W'(1);
                end else begin
                    n_cnt = '0;
                end
                if (n_cnt == CNT_W'(4)) begin
                    n_crc   = crc_magic(i_crc_init);
                    n_total = '0;
                    n_index = '0;
                    n_ptype = '0;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                n_crc = crc_next;
                unique case (r_cnt[3:0])
                    4'd0:    n_total[7:0]   = i_byte;
                    4'd1:    n_total[15:8]  = i_byte;
                    4'd2:    n_index[7:0]   = i_byte;
                    4'd3:    n_index[15:8]  = i_byte;
                    4'd4:    n_ptype[7:0]   = i_byte;
                    4'd5:    n_ptype[15:8]  = i_byte;
                    4'd6:    n_len[7:0]     = i_byte;
                    4'd7:    n_len[15:8]    = i_byte;
                    4'd8:    n_len[23:16]   = i_byte;
                    default: n_len[31:24]   = i_byte;
                endcase
                n_cnt = cnt_inc[CNT_W-1:0];
                if (cnt_inc == (CNT_W+1)'(HEADER_BYTES)) begin
                    n_cnt = '0;
                    if (n_len > limit) begin
                        // abort at once, no payload or CRC is read
                        n_phase      = PH_HUNT;
                        o_res_valid  = 1'b1;
                        o_res.status = ST_TOO_BIG;
                    end else if (n_len == '0) begin
                        n_phase = PH_CRC_LO;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_crc = crc_next;
                n_cnt = cnt_inc[CNT_W-1:0];
                if (cnt_inc == {1'b0, r_len[CNT_W-1:0]}) begin
                    n_cnt   = '0;
                    n_phase = PH_CRC_LO;
                end
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_PAYLOAD;
                o_res.payload_byte = i_byte;
            end
            PH_CRC_LO: begin
                n_crc_lo = i_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_phase      = PH_HUNT;
                n_cnt        = '0;
                o_res_valid  = 1'b1;
                o_res.status = ({i_byte, r_crc_lo} == r_crc) ? ST_OK : ST_CRC_ERR;
            end
            default: begin
                n_phase = PH_HUNT;
                n_cnt   = '0;
            end
        endcase

        o_res.total  = n_total;
        o_res.index  = n_index;
        o_res.ptype  = n_ptype;
        o_res.length = (n_len > LEN_W'(LEN_SAT)) ? LEN_SAT : n_len[OLEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_cnt    <= '0;
            r_total  <= '0;
            r_index  <= '0;
            r_ptype  <= '0;
            r_len    <= '0;
            r_crc    <= CRC_INIT_RST;
            r_crc_lo <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_total  <= n_total;
            r_index  <= n_index;
            r_ptype  <= n_ptype;
            r_len    <= n_len;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule

@@ src/crcpd_out_reg.sv @@
// Result register of the packet deframer: holds one result item until taken.
// Depends on crcpd_pkg.
`timescale 1ns / 1ps

module crcpd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  crcpd_pkg::t_result  i_res,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output crcpd_pkg::t_result  o_res
);
    import crcpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ src/crc_packet_deframer.sv @@
// Packet deframer with CRC16-CCITT check: input register, frame logic, result register.
// A result item is loaded into the result register when its byte leaves the input register.
// Throughput: one byte per cycle, paced only by the result register being taken.
// Reset (synchronous, active low): hunt for magic, counters and fields cleared,
// registers back to CRC init 0xffff and maximum length 1024.
`timescale 1ns / 1ps

module crc_packet_deframer #(
    parameter int MAX_PAYLOAD = crcpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crcpd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [crcpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [crcpd_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_result_kind,
    output logic [crcpd_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic [crcpd_pkg::STATUS_W-1:0]    o_frame_status,
    output logic [crcpd_pkg::FIELD_W-1:0]     o_total_packets,
    output logic [crcpd_pkg::FIELD_W-1:0]     o_packet_number,
    output logic [crcpd_pkg::FIELD_W-1:0]     o_packet_kind,
    output logic [crcpd_pkg::OLEN_W-1:0]      o_payload_length
);
    import crcpd_pkg::*;

    logic [CRC_W-1:0]  r_crc_init;
    logic [OLEN_W-1:0] r_max_len;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              out_free;
    logic              step;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_init <= CRC_INIT_RST;
            r_max_len  <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CRC_INIT: r_crc_init <= i_cfg_data;
                CFG_MAX_LEN:  r_max_len  <= i_cfg_data[OLEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // advance the frame logic only when the result register can take a result
    assign step = byte_valid && out_free;

    crcpd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_take     (step),
        .o_valid    (byte_valid),
        .o_byte     (byte_data)
    );

    crcpd_fsm #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (byte_data),
        .i_crc_init  (r_crc_init),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    crcpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_result_kind    = out_res.kind;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_frame_status   = out_res.status;
    assign o_total_packets  = out_res.total;
    assign o_packet_number  = out_res.index;
    assign o_packet_kind    = out_res.ptype;
    assign o_payload_length = out_res.length;

endmodule

@@ sim/crc_packet_deframer_tb.sv @@
// Self-checking testbench for crc_packet_deframer: builds framed byte streams, predicts
// the forwarded payload and status items in step with the DUT and compares them.
// Depends on src/crcpd_pkg.sv and src/crc_packet_deframer.sv.
`timescale 1ns / 1ps

module crc_packet_deframer_tb;

    import crcpd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]       i_rx_byte   = '0;
    logic                    i_out_ready = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic                    o_result_kind;
    logic [BYTE_W-1:0]       o_payload_byte;
    logic [STATUS_W-1:0]     o_frame_status;
    logic [FIELD_W-1:0]      o_total_packets;
    logic [FIELD_W-1:0]      o_packet_number;
    logic [FIELD_W-1:0]      o_packet_kind;
    logic [OLEN_W-1:0]       o_payload_length;

    crc_packet_deframer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_payload_byte   (o_payload_byte),
        .o_frame_status   (o_frame_status),
        .o_total_packets  (o_total_packets),
        .o_packet_number  (o_packet_number),
        .o_packet_kind    (o_packet_kind),
        .o_payload_length (o_payload_length)
    );

    // deframer state as the testbench sees it
    t_phase              dfr_phase;
    logic [10:0]         dfr_pos;
    logic [15:0]         hdr_total;
    logic [15:0]         hdr_index;
    logic [15:0]         hdr_kind;
    logic [31:0]         hdr_len;
    logic [15:0]         crc_acc;
    logic [7:0]          crc_lo;
    logic [15:0]         crc_seed;
    logic [10:0]         max_len_reg;

    logic [7:0]          link_bytes[$];
    t_result             results_due[$];
    int                  bytes_issued = 0;
    int                  bytes_taken  = 0;
    int                  results_seen = 0;
    int                  errors       = 0;
    int                  stall_cycles = 0;
    bit                  in_took      = 1'b0;
    bit                  out_took     = 1'b0;
    int                  tx_wait      = 0;
    bit                  tx_calm      = 1'b0;
    int                  rx_wait      = 0;
    bit                  rx_calm      = 1'b0;
    int                  hold_left    = 0;
    bit                  held_long    = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            if (c[15] ^ d[i]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic int active_limit();
        return (max_len_reg > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(max_len_reg);
    endfunction

    function automatic t_result frame_item(input logic kind, input logic [7:0] b,
                                           input logic [1:0] st);
        t_result r;
        r.kind         = kind;
        r.payload_byte = b;
        r.status       = st;
        r.total        = hdr_total;
        r.index        = hdr_index;
        r.ptype        = hdr_kind;
        r.length       = (hdr_len > LEN_SAT) ? LEN_SAT : hdr_len[10:0];
        return r;
    endfunction

    // advance the deframer by one byte; returns 1 when the byte yields a result item
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        logic [7:0] want;
        bit         emit;
        emit = 1'b0;
        r    = '0;
        case (dfr_phase)
            PH_HUNT: begin
                want = (dfr_pos < 2) ? MAGIC_LO : MAGIC_HI;
                if (b == want) begin
                    dfr_pos = dfr_pos + 11'd1;
                end else if (b == MAGIC_LO) begin
                    // a broken match may still be the start of a new one
                    dfr_pos = (dfr_pos == 2) ? 11'd2 : 11'd1;
                end else begin
                    dfr_pos = '0;
                end
                if (dfr_pos >= 4) begin
                    crc_acc   = crc16_update(crc_seed, MAGIC_LO);
                    crc_acc   = crc16_update(crc_acc, MAGIC_LO);
                    crc_acc   = crc16_update(crc_acc, MAGIC_HI);
                    crc_acc   = crc16_update(crc_acc, MAGIC_HI);
                    hdr_total = '0;
                    hdr_index = '0;
                    hdr_kind  = '0;
                    hdr_len   = '0;
                    dfr_pos   = '0;
                    dfr_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                crc_acc = crc16_update(crc_acc, b);
                if (dfr_pos < 2) begin
                    hdr_total[8*dfr_pos +: 8] = b;
                end else if (dfr_pos < 4) begin
                    hdr_index[8*(dfr_pos-2) +: 8] = b;
                end else if (dfr_pos < 6) begin
                    hdr_kind[8*(dfr_pos-4) +: 8] = b;
                end else begin
                    hdr_len[8*(dfr_pos-6) +: 8] = b;
                end
                dfr_pos = dfr_pos + 11'd1;
                if (dfr_pos == HEADER_BYTES) begin
                    dfr_pos = '0;
                    if (hdr_len > active_limit()) begin
                        // abort the frame, hunt again
                        dfr_phase = PH_HUNT;
                        r    = frame_item(KIND_STATUS, 8'h00, ST_TOO_BIG);
                        emit = 1'b1;
                    end else begin
                        dfr_phase = (hdr_len == 0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_acc = crc16_update(crc_acc, b);
                dfr_pos = dfr_pos + 11'd1;
                if (dfr_pos >= hdr_len) begin
                    dfr_pos   = '0;
                    dfr_phase = PH_CRC_LO;
                end
                r    = frame_item(KIND_PAYLOAD, b, ST_OK);
                emit = 1'b1;
            end
            PH_CRC_LO: begin
                crc_lo    = b;
                dfr_phase = PH_CRC_HI;
            end
            default: begin
                dfr_phase = PH_HUNT;
                dfr_pos   = '0;
                r    = frame_item(KIND_STATUS, 8'h00, ({b, crc_lo} == crc_acc) ? ST_OK : ST_CRC_ERR);
                emit = 1'b1;
            end
        endcase
        return emit;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // predict on every accepted byte, check every accepted result item
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            in_took  = i_in_valid && o_in_ready;
            out_took = o_out_valid && i_out_ready;
            if (in_took) begin
                bytes_taken++;
                if (deframe_byte(i_rx_byte, r)) begin
                    results_due.push_back(r);
                end
            end
            if (out_took) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    $error("result item with no expectation pending");
                    errors++;
                end else begin
                    r = results_due.pop_front();
                    check_field("result_kind", 16'(r.kind), 16'(o_result_kind));
                    check_field("payload_byte", 16'(r.payload_byte), 16'(o_payload_byte));
                    check_field("frame_status", 16'(r.status), 16'(o_frame_status));
                    check_field("total_packets", r.total, o_total_packets);
                    check_field("packet_number", r.index, o_packet_number);
                    check_field("packet_kind", r.ptype, o_packet_kind);
                    check_field("payload_length", 16'(r.length), 16'(o_payload_length));
                end
            end
            if (in_took || out_took) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // byte driver: hold each item until taken, then idle for a drawn number of cycles
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_took)) begin
            if (tx_wait > 0) begin
                tx_wait--;
                i_in_valid <= 1'b0;
            end else if (link_bytes.size() != 0) begin
                i_rx_byte  <= link_bytes.pop_front();
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
                tx_wait = tx_calm ? 0 : $urandom_range(0, 11);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_took) begin
                if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
            end
            if (!held_long && results_seen >= 300) begin
                hold_left = LONG_HOLD;
                held_long = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        bytes_issued++;
    endtask

    function automatic logic [7:0] biased_byte();
        case ($urandom_range(0, 7))
            0:       return MAGIC_LO;
            1:       return MAGIC_HI;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame: magic, header, then payload and CRC unless the length is rejected
    task automatic add_frame(input logic [15:0] tot, input logic [15:0] idx,
                             input logic [15:0] knd, input logic [31:0] len,
                             input bit spoil, input bit magic_body);
        logic [15:0] c;
        logic [79:0] hdr;
        logic [7:0]  b;
        c   = crc_seed;
        hdr = {len, knd, idx, tot};
        for (int i = 0; i < 4; i++) begin
            b = (i < 2) ? MAGIC_LO : MAGIC_HI;
            push_byte(b);
            c = crc16_update(c, b);
        end
        for (int i = 0; i < 10; i++) begin
            b = hdr[8*i +: 8];
            push_byte(b);
            c = crc16_update(c, b);
        end
        if (len > active_limit()) return;
        for (int i = 0; i < len; i++) begin
            if (magic_body) begin
                b = ((i % 4) < 2) ? MAGIC_LO : MAGIC_HI;
            end else begin
                b = biased_byte();
            end
            push_byte(b);
            c = crc16_update(c, b);
        end
        if (spoil) c = c ^ (16'h0001 << $urandom_range(0, 15));
        push_byte(c[7:0]);
        push_byte(c[15:8]);
    endtask

    task automatic add_random_unit();
        int          r;
        int          lim;
        int          n;
        logic [31:0] len;
        logic [15:0] knd;
        r   = $urandom_range(0, 99);
        lim = active_limit();
        if (r < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) push_byte(biased_byte());
        end else if (r < 13) begin
            // magic cut short
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) push_byte((i < 2) ? MAGIC_LO : MAGIC_HI);
            push_byte(8'($urandom_range(0, 84)));
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    len = 0;
                2, 3, 4, 5, 6: len = $urandom_range(1, 12);
                7:       len = (lim <= 48) ? lim : $urandom_range(13, 48);
                8:       len = lim + 1 + $urandom_range(0, 2);
                default: begin
                    len = $urandom;
                    if (len <= lim) len = lim + 1 + len[3:0];
                end
            endcase
            knd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
            add_frame(16'($urandom), 16'($urandom), knd, len, $urandom_range(0, 4) == 0,
                      $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic fill_random(input int n);
        int target;
        target = bytes_issued + n;
        while (bytes_issued < target) add_random_unit();
    endtask

    // wait until every byte is taken and every result item is in, then let the pipe empty
    task automatic wait_idle();
        do @(negedge i_clk); while (bytes_taken != bytes_issued || results_due.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CRC_INIT) begin
            crc_seed = val;
        end else begin
            max_len_reg = val[10:0];
        end
    endtask

    task automatic set_phase(input logic [15:0] seed, input logic [15:0] max_len);
        wait_idle();
        write_reg(CFG_CRC_INIT, seed);
        write_reg(CFG_MAX_LEN, max_len);
    endtask

    initial begin
        crc_seed    = CRC_INIT_RST;
        max_len_reg = MAX_LEN_RST;
        dfr_phase   = PH_HUNT;
        dfr_pos     = '0;
        hdr_total   = '0;
        hdr_index   = '0;
        hdr_kind    = '0;
        hdr_len     = '0;
        crc_acc     = CRC_INIT_RST;
        crc_lo      = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // byte extremes, magic preceded by an extra 55, magic pattern inside the payload
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(MAGIC_LO);
        add_frame(16'hffff, 16'h0000, 16'h0002, 32'd4, 1'b0, 1'b1);
        fill_random(150);

        set_phase(16'h0000, 16'd1024);
        fill_random(150);

        set_phase(16'($urandom), 16'd0);
        fill_random(120);

        set_phase(16'hffff, 16'd8);
        fill_random(150);

        // upper register bits are dropped; the limit caps at the build maximum
        set_phase(16'($urandom), 16'hffff);
        add_frame(16'($urandom), 16'($urandom), 16'h0002, 32'd1024, 1'b0, 1'b0);
        add_frame(16'($urandom), 16'($urandom), 16'h0002, 32'd1025, 1'b0, 1'b0);
        fill_random(100);

        set_phase(16'($urandom), 16'($urandom_range(0, 1024)));
        fill_random(150);

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
